[design/bdc_pkg.sv]
`default_nettype none

package bdc_pkg;

    // field widths of one beat
    localparam int DC_W    = 25;
    localparam int YEAR_W  = 17;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;

    // action codes
    localparam logic ACT_TO_FIXED = 1'b0;
    localparam logic ACT_TO_DATE  = 1'b1;

    // anno mundi offsets: january..august and september..december
    localparam int AM_JAN_OFS = 5508;
    localparam int AM_SEP_OFS = 5509;

    // byzantine month 1 is julian september
    localparam int BYZ_MONTH_SHIFT = 8;
    localparam int MONTHS          = 12;

    // julian year estimate: floor((4 * days + 1464) / 1461)
    localparam int DAYS_4YR     = 1461;
    localparam int YEAR_EST_OFS = 1464;
    // years added so the year division only sees non-negative numerators
    localparam int YEAR_BIAS    = 65536;
    localparam int DAYS_YEAR    = 365;

    // month estimate: floor((12 * days + 373) / 367)
    localparam int MONTH_DIV     = 367;
    localparam int MONTH_EST_OFS = 373;

    // day of year of march 1, leap and common year (0 based)
    localparam int MAR1_LEAP   = 60;
    localparam int MAR1_COMMON = 59;

    // internal widths
    localparam int YR_W    = 18;  // julian year minus one
    localparam int NUM_W   = 28;  // year division numerator
    localparam int QYR_W   = 17;  // biased year quotient
    localparam int P365_W  = 27;
    localparam int PRIOR_W = 9;   // day of year, 0..365
    localparam int XM_W    = 13;  // month division numerator
    localparam int MSTART_W = 10;

    // floor((367 * m - 362) / 12): days before julian month m if february had 30 days
    function automatic logic signed [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic signed [MSTART_W-1:0] v;
        case (m)
            4'd0:    v = -10'sd31;
            4'd1:    v = 10'sd0;
            4'd2:    v = 10'sd31;
            4'd3:    v = 10'sd61;
            4'd4:    v = 10'sd92;
            4'd5:    v = 10'sd122;
            4'd6:    v = 10'sd153;
            4'd7:    v = 10'sd183;
            4'd8:    v = 10'sd214;
            4'd9:    v = 10'sd245;
            4'd10:   v = 10'sd275;
            4'd11:   v = 10'sd306;
            4'd12:   v = 10'sd336;
            4'd13:   v = 10'sd367;
            default: v = 10'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/bdc_req_if.sv]
`default_nettype none

interface bdc_req_if import bdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic signed [DC_W-1:0]    day_count;
    logic signed [YEAR_W-1:0]  date_year;
    logic        [MONTH_W-1:0] date_month;
    logic        [DAY_W-1:0]   date_day;

    modport source (
        output valid, action, day_count, date_year, date_month, date_day,
        input  ready
    );
    modport sink (
        input  valid, action, day_count, date_year, date_month, date_day,
        output ready
    );
endinterface

`default_nettype wire

[design/bdc_res_if.sv]
`default_nettype none

interface bdc_res_if import bdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DC_W-1:0]    out_day_count;
    logic signed [YEAR_W-1:0]  out_year;
    logic        [MONTH_W-1:0] out_month;
    logic        [DAY_W-1:0]   out_day;

    modport source (
        output valid, out_day_count, out_year, out_month, out_day,
        input  ready
    );
    modport sink (
        input  valid, out_day_count, out_year, out_month, out_day,
        output ready
    );
endinterface

`default_nettype wire

[design/byzantine_date_converter.sv]
// channel  | dir | modport | payload
// ---------+-----+---------+---------------------------------------------------
// i_req    | in  | sink    | action, day_count, date_year, date_month, date_day
// o_res    | out | source  | out_day_count, out_year, out_month, out_day
//
// eight register stages; one beat enters per cycle while the output is not
// held off, and a result leaves from the output register after stage 7.
// the stage count is set by the two reciprocal multiplies (year and month estimates)
// and the two day-offset multiplies by 365 that sit in separate stages.
// each stage holds its beat until the next one frees, so bubbles close up
// under stalls and nothing is dropped or repeated.
// reset (synchronous, active low) clears the stage valid bits only.
`default_nettype none

module byzantine_date_converter import bdc_pkg::*; #(
    parameter int JULIAN_EPOCH_DAY = -1
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bdc_req_if.sink    i_req,
    bdc_res_if.source  o_res
);

    localparam int NSTG = 7;

    localparam logic signed [29:0] N_BIAS =
        30'(DAYS_4YR * YEAR_BIAS + YEAR_EST_OFS - 4 * JULIAN_EPOCH_DAY);
    localparam logic signed [11:0] EPOCH_M1 = 12'(JULIAN_EPOCH_DAY - 1);
    localparam logic signed [NUM_W-1:0] EPOCH_N = NUM_W'(JULIAN_EPOCH_DAY);
    localparam logic signed [YR_W-1:0] YM1_BIAS = YR_W'(YEAR_BIAS + 1);
    localparam logic signed [YR_W-1:0] AM_YM1   = YR_W'(AM_SEP_OFS + 1);

    // stage handshake
    logic [NSTG:1]   r_vld;
    logic [NSTG+1:1] adv;
    logic            r_out_vld;

    always_comb begin
        adv[NSTG+1] = !r_out_vld || o_res.ready;
        for (int k = NSTG; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign i_req.ready = adv[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_req.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (adv[NSTG+1]) begin
                r_out_vld <= r_vld[NSTG];
            end
        end
    end

    // ---------------- stage 1: julian month/year, year numerator
    logic [4:0]             m8;
    logic                   wrap;
    logic signed [29:0]     num_sum;
    logic [NSTG:1]          r_act;
    logic signed [DC_W-1:0] r1_rd;
    logic [NUM_W-1:0]       r1_num;
    logic signed [YR_W-1:0] r1_ym1;
    logic [MONTH_W-1:0]     r1_mon;
    logic [DAY_W-1:0]       r1_day;

    // action bit rides along with each stage
    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_act[1] <= i_req.action;
        end
        for (int k = 2; k <= NSTG; k++) begin
            if (adv[k]) begin
                r_act[k] <= r_act[k-1];
            end
        end
    end

    assign m8      = {1'b0, i_req.date_month} + 5'(BYZ_MONTH_SHIFT);
    assign wrap    = m8 > 5'(MONTHS);
    assign num_sum = (30'(i_req.day_count) <<< 2) + N_BIAS;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r1_rd    <= i_req.day_count;
            r1_num   <= num_sum[NUM_W-1:0];
            r1_ym1   <= YR_W'(i_req.date_year) - AM_YM1 + YR_W'({1'b0, wrap});
            r1_mon   <= wrap ? 4'(m8 - 5'(MONTHS)) : m8[3:0];
            r1_day   <= i_req.date_day;
        end
    end

    // ---------------- stage 2: year division, 365 * (y - 1) for dates
    logic [QYR_W-1:0]         q_year;
    logic                     leap1;
    logic [11:0]              adj1;
    logic signed [DC_W-1:0]   r2_rd;
    logic signed [P365_W-1:0] r2_p365;
    logic signed [YR_W-1:0]   r2_fl;
    logic signed [11:0]       r2_small;

    bdc_cdiv #(
        .NUM_W   (NUM_W),
        .DIVISOR (DAYS_4YR),
        .QUO_W   (QYR_W)
    ) u_year_div (
        .i_clk (i_clk),
        .i_en  (adv[2]),
        .i_num (r1_num),
        .o_quo (q_year)
    );

    // leap year of y is y - 1 == 3 mod 4
    assign leap1 = &r1_ym1[1:0];
    assign adj1  = (r1_mon > 4'd2) ? (leap1 ? 12'd1 : 12'd2) : 12'd0;

    always_ff @(posedge i_clk) begin
        if (adv[2]) begin
            r2_rd    <= r1_rd;
            r2_p365  <= P365_W'(r1_ym1) * P365_W'(DAYS_YEAR);
            r2_fl    <= r1_ym1 >>> 2;
            r2_small <= 12'(month_start(r1_mon)) + 12'({7'd0, r1_day}) + EPOCH_M1 - adj1;
        end
    end

    // ---------------- stage 3: fixed day of a date, unbias the year
    logic signed [NUM_W-1:0] dc_sum;
    logic signed [DC_W-1:0]  r3_rd;
    logic signed [DC_W-1:0]  r3_dc;
    logic signed [YR_W-1:0]  r3_ym1;

    assign dc_sum = NUM_W'(r2_p365) + NUM_W'(r2_fl) + NUM_W'(r2_small);

    always_ff @(posedge i_clk) begin
        if (adv[3]) begin
            r3_rd    <= r2_rd;
            r3_dc    <= dc_sum[DC_W-1:0];
            r3_ym1   <= $signed({1'b0, q_year}) - YM1_BIAS;
        end
    end

    // ---------------- stage 4: start of the julian year
    logic signed [DC_W-1:0]   r4_rd;
    logic signed [DC_W-1:0]   r4_dc;
    logic signed [YR_W-1:0]   r4_ym1;
    logic signed [P365_W-1:0] r4_p365;
    logic signed [YR_W-1:0]   r4_fl;
    logic                     r4_leap;

    always_ff @(posedge i_clk) begin
        if (adv[4]) begin
            r4_rd    <= r3_rd;
            r4_dc    <= r3_dc;
            r4_ym1   <= r3_ym1;
            r4_p365  <= P365_W'(r3_ym1) * P365_W'(DAYS_YEAR);
            r4_fl    <= r3_ym1 >>> 2;
            r4_leap  <= &r3_ym1[1:0];
        end
    end

    // ---------------- stage 5: day of year
    logic signed [NUM_W-1:0] prior_sum;
    logic signed [DC_W-1:0]  r5_dc;
    logic signed [YR_W-1:0]  r5_ym1;
    logic                    r5_leap;
    logic [PRIOR_W-1:0]      r5_prior;

    assign prior_sum = NUM_W'(r4_rd) - NUM_W'(r4_p365) - NUM_W'(r4_fl) - EPOCH_N;

    always_ff @(posedge i_clk) begin
        if (adv[5]) begin
            r5_dc    <= r4_dc;
            r5_ym1   <= r4_ym1;
            r5_leap  <= r4_leap;
            r5_prior <= prior_sum[PRIOR_W-1:0];
        end
    end

    // ---------------- stage 6: month numerator with the february correction
    logic [1:0]             corr;
    logic [PRIOR_W-1:0]     ppc;
    logic signed [DC_W-1:0] r6_dc;
    logic signed [YR_W-1:0] r6_ym1;
    logic                   r6_leap;
    logic [PRIOR_W-1:0]     r6_prior;
    logic [XM_W-1:0]        r6_x;

    always_comb begin
        if (r5_leap) begin
            corr = (r5_prior >= PRIOR_W'(MAR1_LEAP)) ? 2'd1 : 2'd0;
        end else begin
            corr = (r5_prior >= PRIOR_W'(MAR1_COMMON)) ? 2'd2 : 2'd0;
        end
    end

    assign ppc = r5_prior + PRIOR_W'(corr);

    always_ff @(posedge i_clk) begin
        if (adv[6]) begin
            r6_dc    <= r5_dc;
            r6_ym1   <= r5_ym1;
            r6_leap  <= r5_leap;
            r6_prior <= r5_prior;
            r6_x     <= XM_W'(ppc) * XM_W'(MONTHS) + XM_W'(MONTH_EST_OFS);
        end
    end

    // ---------------- stage 7: month division
    logic [MONTH_W-1:0]     q_mon;
    logic signed [DC_W-1:0] r7_dc;
    logic signed [YR_W-1:0] r7_ym1;
    logic                   r7_leap;
    logic [PRIOR_W-1:0]     r7_prior;

    bdc_cdiv #(
        .NUM_W   (XM_W),
        .DIVISOR (MONTH_DIV),
        .QUO_W   (MONTH_W)
    ) u_month_div (
        .i_clk (i_clk),
        .i_en  (adv[7]),
        .i_num (r6_x),
        .o_quo (q_mon)
    );

    always_ff @(posedge i_clk) begin
        if (adv[7]) begin
            r7_dc    <= r6_dc;
            r7_ym1   <= r6_ym1;
            r7_leap  <= r6_leap;
            r7_prior <= r6_prior;
        end
    end

    // ---------------- output register: day of month, byzantine year and month
    logic [11:0]               adj7;
    logic [11:0]               dom;
    logic signed [YR_W-1:0]    byear;
    logic [MONTH_W-1:0]        bmon;
    logic signed [DC_W-1:0]    r_out_dc;
    logic signed [YEAR_W-1:0]  r_out_year;
    logic [MONTH_W-1:0]        r_out_mon;
    logic [DAY_W-1:0]          r_out_day;

    assign adj7  = (q_mon > 4'd2) ? (r7_leap ? 12'd1 : 12'd2) : 12'd0;
    assign dom   = 12'(r7_prior) + 12'd1 - 12'(month_start(q_mon)) + adj7;
    assign byear = r7_ym1 + YR_W'(1) +
                   ((q_mon < 4'(BYZ_MONTH_SHIFT + 1)) ? YR_W'(AM_JAN_OFS) : YR_W'(AM_SEP_OFS));
    assign bmon  = (q_mon > 4'(BYZ_MONTH_SHIFT)) ? q_mon - 4'(BYZ_MONTH_SHIFT)
                                                 : q_mon + 4'(MONTHS - BYZ_MONTH_SHIFT);

    always_ff @(posedge i_clk) begin
        if (adv[NSTG+1]) begin
            if (r_act[7] == ACT_TO_DATE) begin
                r_out_dc   <= '0;
                r_out_year <= byear[YEAR_W-1:0];
                r_out_mon  <= bmon;
                r_out_day  <= dom[DAY_W-1:0];
            end else begin
                r_out_dc   <= r7_dc;
                r_out_year <= '0;
                r_out_mon  <= '0;
                r_out_day  <= '0;
            end
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.out_day_count = r_out_dc;
    assign o_res.out_year      = r_out_year;
    assign o_res.out_month     = r_out_mon;
    assign o_res.out_day       = r_out_day;

endmodule

`default_nettype wire

[design/bdc_cdiv.sv]
`default_nettype none

// unsigned divide by a constant: one registered multiply by the rounded-up
// reciprocal, exact for every numerator below 2**NUM_W
module bdc_cdiv #(
    parameter int NUM_W   = 28,
    parameter int DIVISOR = 1461,
    parameter int QUO_W   = 17
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    output logic [QUO_W-1:0] o_quo
);

    localparam int LOG_D   = $clog2(DIVISOR);
    localparam int SHIFT   = NUM_W + LOG_D;
    localparam int RECIP_W = NUM_W + 1;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_num) * PROD_W'(RECIP[RECIP_W-1:0]);
        end
    end

    assign o_quo = r_prod[SHIFT +: QUO_W];

endmodule

`default_nettype wire

[design/bdc_checker.sv]
`default_nettype none

module bdc_checker import bdc_pkg::*; (
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_out_valid,
    input wire logic                      i_out_ready,
    input wire logic signed [DC_W-1:0]    i_out_day_count,
    input wire logic signed [YEAR_W-1:0]  i_out_year,
    input wire logic        [MONTH_W-1:0] i_out_month,
    input wire logic        [DAY_W-1:0]   i_out_day
);

    // no result beat right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat valid after reset");

    // a held result beat stays offered
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    // a date result has a real month and day and no day count
    a_date_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_month != '0) |->
            (i_out_day_count == '0) && (i_out_month <= 4'(MONTHS)) && (i_out_day != '0))
        else $error("date result out of range");

    // a day count result leaves the date fields clear
    a_count_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_month == '0) |-> (i_out_year == '0) && (i_out_day == '0))
        else $error("day count result with date fields set");

endmodule

bind byzantine_date_converter bdc_checker u_bdc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_res.valid),
    .i_out_ready     (o_res.ready),
    .i_out_day_count (o_res.out_day_count),
    .i_out_year      (o_res.out_year),
    .i_out_month     (o_res.out_month),
    .i_out_day       (o_res.out_day)
);

`default_nettype wire
